@@ rtl/reprojection_error_engine_unit_defines.svh @@
// assertion macros for the reprojection error engine
// no dependencies
`ifndef REPROJECTION_ERROR_ENGINE_UNIT_DEFINES_SVH
`define REPROJECTION_ERROR_ENGINE_UNIT_DEFINES_SVH
// check that an implication holds at every rising clock edge outside reset
`define REE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// check that the consequence holds in the cycle after the antecedent
`define REE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/ree_pkg.sv @@
// shared constants and types for the reprojection error engine
// no dependencies
package ree_pkg;
   localparam int unsigned MaxPoints = 65536;
   localparam int unsigned CountW = 17;
   localparam int unsigned SumW = 49;
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_WZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;
   localparam logic [2:0] CSR_R0L = 3'd0;
   localparam logic [2:0] CSR_R0R = 3'd1;
   localparam logic [2:0] CSR_R1L = 3'd2;
   localparam logic [2:0] CSR_R1R = 3'd3;
   localparam logic [2:0] CSR_R2L = 3'd4;
   localparam logic [2:0] CSR_R2R = 3'd5;
   typedef logic [63:0] csr_data_type;
endpackage

@@ rtl/reprojection_error_engine_unit.sv @@
// Pinhole camera reprojection error engine: projects a world point through a
// configured 3x4 camera matrix and reports pixel, distance and set mean.
// Depends on ree_pkg and reprojection_error_engine_unit_defines.svh.
//
// One request at a time. The nine row products run one bit per cycle
// through a shift-and-add multiplier, each division is bit-serial
// restoring with setup and saturation, the squares are shift-and-add,
// the square root is taken digit by digit, and the set mean is a 49-step
// restoring division; all these share one sequencer. A request with w of
// zero skips the divisions, squares and square root. The next request can
// be accepted the cycle after the result is registered; a result that is
// not taken holds the next result in the sequencer, and with it the request
// side, until the result channel accepts it.
`include "reprojection_error_engine_unit_defines.svh"
module reprojection_error_engine_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [31:0]   req_world_x,
   input  logic signed [31:0]   req_world_y,
   input  logic signed [31:0]   req_world_z,
   input  logic signed [31:0]   req_image_x,
   input  logic signed [31:0]   req_image_y,
   input  logic                 req_last_point,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_proj_x,
   output logic signed [31:0]   rsp_proj_y,
   output logic [31:0]          rsp_point_error,
   output logic [31:0]          rsp_mean_error,
   output logic                 rsp_set_done,
   output logic [1:0]           rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  ree_pkg::csr_data_type csr_data
);
   import ree_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL = 4'd1;
   localparam logic [3:0] ST_ACC = 4'd2;
   localparam logic [3:0] ST_DIV = 4'd3;
   localparam logic [3:0] ST_DIVEND = 4'd4;
   localparam logic [3:0] ST_SQ = 4'd5;
   localparam logic [3:0] ST_SQRT = 4'd6;
   localparam logic [3:0] ST_SUM = 4'd7;
   localparam logic [3:0] ST_MEAN = 4'd8;
   localparam logic [3:0] ST_OUT = 4'd9;
   localparam logic [3:0] ST_PROD = 4'd10;
   localparam logic [3:0] ST_ROOT = 4'd11;
   localparam logic [3:0] ST_MEANEND = 4'd12;

   logic [63:0] cam_ff [6];
   logic [3:0]  state_ff;
   logic [6:0]  cnt_ff;
   logic [3:0]  term_ff;       // row*4+col for products, row for divides
   logic signed [31:0] pt_ff [5];
   logic        last_ff;
   logic signed [48:0] rsum_ff [3];
   // shared shift-add multiplier
   logic [63:0] mprod_ff;
   logic [31:0] mcand_ff, mplier_ff;
   logic        mneg_ff;
   // shared restoring divider: remainder and quotient
   logic [47:0] drem_ff;
   logic [63:0] dq_ff;
   logic [63:0] dnum_ff;
   logic [47:0] dden_ff;
   logic        dneg_ff;
   logic signed [31:0] px_ff, py_ff;
   logic        sat_ff, wzero_ff;
   logic [64:0] sq_ff;
   logic [63:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] err_ff;
   logic [SumW-1:0] sum_ff;
   logic [CountW-1:0] count_ff;
   logic [31:0] mean_ff;
   logic        out_valid_ff;
   logic signed [31:0] o_px_ff, o_py_ff;
   logic [31:0] o_err_ff, o_mean_ff;
   logic        o_done_ff;
   logic [1:0]  o_status_ff;

   logic [1:0] row;
   logic [1:0] col;
   logic signed [31:0] coef;
   logic signed [31:0] coord;
   logic signed [63:0] sprod;
   logic signed [48:0] prod_floor;
   logic signed [48:0] div_row;
   logic [49:0] dtrial;
   logic [47:0] abs_num;
   logic [32:0] diff_a;
   logic [31:0] adiff;
   logic [SumW:0] sum_add;
   logic [63:0] sat_q;

   assign row = term_ff[3:2];
   assign col = term_ff[1:0];
   assign req_ready = !reset && (state_ff == ST_IDLE);
   assign csr_ready = !reset && (state_ff == ST_IDLE) && !out_valid_ff;

   always_comb begin
      coef = '0;
      case (col)
         2'd0: coef = cam_ff[{1'b0, row} << 1][31:0];
         2'd1: coef = cam_ff[{1'b0, row} << 1][63:32];
         2'd2: coef = cam_ff[({1'b0, row} << 1) + 3'd1][31:0];
         default: coef = cam_ff[({1'b0, row} << 1) + 3'd1][63:32];
      endcase
      case (col)
         2'd0: coord = pt_ff[0];
         2'd1: coord = pt_ff[1];
         default: coord = pt_ff[2];
      endcase
   end

   assign sprod = mneg_ff ? -$signed(mprod_ff) : $signed(mprod_ff);
   assign prod_floor = 49'(sprod >>> 16);
   assign dtrial = {1'b0, drem_ff, dnum_ff[63]} - {2'b00, dden_ff};
   // term 0 divides row 0, term 1 divides row 1
   assign div_row = term_ff[0] ? rsum_ff[1] : rsum_ff[0];
   always_comb begin
      abs_num = div_row[48] ? 48'(-div_row) : div_row[47:0];
      diff_a = term_ff[0] ? 33'($signed(py_ff)) - 33'($signed(pt_ff[4]))
                          : 33'($signed(px_ff)) - 33'($signed(pt_ff[3]));
      adiff = diff_a[32] ? 32'(-diff_a) : diff_a[31:0];
      sum_add = {1'b0, sum_ff} + {18'd0, err_ff};
      sat_q = dq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < 6; i++) cam_ff[i] <= '0;
      end else begin
         if (out_valid_ff && rsp_ready && state_ff != ST_OUT) out_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_R0L: cam_ff[0] <= csr_data;
               CSR_R0R: cam_ff[1] <= csr_data;
               CSR_R1L: cam_ff[2] <= csr_data;
               CSR_R1R: cam_ff[3] <= csr_data;
               CSR_R2L: cam_ff[4] <= csr_data;
               CSR_R2R: cam_ff[5] <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               pt_ff[0] <= req_world_x;
               pt_ff[1] <= req_world_y;
               pt_ff[2] <= req_world_z;
               pt_ff[3] <= req_image_x;
               pt_ff[4] <= req_image_y;
               last_ff <= req_last_point;
               term_ff <= '0;
               cnt_ff <= '0;
               sat_ff <= 1'b0;
               state_ff <= ST_ACC;
               for (int r = 0; r < 3; r++) rsum_ff[r] <= '0;
            end
            // load next product or finish rows
            ST_ACC: begin
               if (col == 2'd3) begin
                  rsum_ff[row] <= rsum_ff[row] + 49'(coef);
                  if (row == 2'd2) begin
                     term_ff <= '0;
                     state_ff <= ST_DIV;
                     cnt_ff <= '0;
                     wzero_ff <= (rsum_ff[2] + 49'(coef)) == '0;
                  end else term_ff <= {row + 2'd1, 2'd0};
               end else begin
                  mcand_ff <= coef[31] ? 32'(-coef) : coef;
                  mplier_ff <= coord[31] ? 32'(-coord) : coord;
                  mneg_ff <= coef[31] ^ coord[31];
                  mprod_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // one multiplier bit per cycle, msb first
               mprod_ff <= (mprod_ff << 1) +
                  (mplier_ff[31] ? {32'd0, mcand_ff} : 64'd0);
               mplier_ff <= mplier_ff << 1;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd31) state_ff <= ST_PROD;
            end
            ST_PROD: begin
               rsum_ff[row] <= rsum_ff[row] + prod_floor;
               term_ff <= term_ff + 4'd1;
               state_ff <= ST_ACC;
            end
            ST_DIV: begin
               if (cnt_ff == 7'd0) begin
                  if (wzero_ff) begin
                     px_ff <= rsum_ff[0][48] ? 32'h8000_0000 :
                        (rsum_ff[0] != '0 ? 32'h7FFF_FFFF : 32'd0);
                     py_ff <= rsum_ff[1][48] ? 32'h8000_0000 :
                        (rsum_ff[1] != '0 ? 32'h7FFF_FFFF : 32'd0);
                     err_ff <= '1;
                     state_ff <= ST_SUM;
                  end else begin
                     dnum_ff <= {abs_num, 16'd0};
                     dden_ff <= rsum_ff[2][48] ? 48'(-rsum_ff[2]) : rsum_ff[2][47:0];
                     dneg_ff <= div_row[48] ^ rsum_ff[2][48];
                     drem_ff <= '0;
                     dq_ff <= '0;
                     cnt_ff <= 7'd1;
                  end
               end else begin
                  // numerator is |row| << 16, 64 bits, shifted in msb first
                  if (!dtrial[49]) begin
                     drem_ff <= dtrial[47:0];
                     dq_ff <= {dq_ff[62:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[46:0], dnum_ff[63]};
                     dq_ff <= {dq_ff[62:0], 1'b0};
                  end
                  dnum_ff <= dnum_ff << 1;
                  cnt_ff <= cnt_ff + 7'd1;
                  if (cnt_ff == 7'd64) state_ff <= ST_DIVEND;
               end
            end
            ST_DIVEND: begin
               if (dneg_ff ? (sat_q > 64'h8000_0000) : (sat_q > 64'h7FFF_FFFF)) begin
                  sat_ff <= 1'b1;
                  if (term_ff[0]) py_ff <= dneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  else px_ff <= dneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  if (term_ff[0]) py_ff <= dneg_ff ? 32'(-sat_q) : sat_q[31:0];
                  else px_ff <= dneg_ff ? 32'(-sat_q) : sat_q[31:0];
               end
               cnt_ff <= '0;
               if (term_ff[0]) begin
                  term_ff <= '0;
                  sq_ff <= '0;
                  state_ff <= ST_SQ;
               end else begin
                  term_ff <= 4'd1;
                  state_ff <= ST_DIV;
               end
            end
            ST_SQ: begin
               if (cnt_ff == 7'd0) begin
                  mcand_ff <= adiff;
                  mplier_ff <= adiff;
                  mprod_ff <= '0;
                  cnt_ff <= 7'd1;
               end else if (cnt_ff <= 7'd32) begin
                  mprod_ff <= (mprod_ff << 1) +
                     (mplier_ff[31] ? {32'd0, mcand_ff} : 64'd0);
                  mplier_ff <= mplier_ff << 1;
                  cnt_ff <= cnt_ff + 7'd1;
               end else begin
                  sq_ff <= sq_ff + {1'b0, mprod_ff};
                  cnt_ff <= '0;
                  if (term_ff[0]) begin
                     state_ff <= ST_SQRT;
                     rem_ff <= '0;
                     root_ff <= '0;
                     dq_ff <= sq_ff[63:0] + mprod_ff;
                     term_ff <= '0;
                  end else term_ff <= 4'd1;
               end
            end
            ST_SQRT: begin
               // two radicand bits per cycle, 32 result bits
               if ({2'b00, rem_ff[61:0], dq_ff[63:62]} >= {32'd0, root_ff, 2'b01}) begin
                  rem_ff <= {rem_ff[61:0], dq_ff[63:62]} - {30'd0, root_ff, 2'b01};
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[61:0], dq_ff[63:62]};
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               dq_ff <= dq_ff << 2;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd31) state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_ff[64]) begin
                  err_ff <= '1;
                  sat_ff <= 1'b1;
               end else err_ff <= root_ff;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (count_ff < CountW'(MaxPoints)) begin
                  sum_ff <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
                  count_ff <= count_ff + CountW'(1);
               end
               mean_ff <= '0;
               cnt_ff <= '0;
               state_ff <= last_ff ? ST_MEAN : ST_OUT;
            end
            ST_MEAN: begin
               if (cnt_ff == 7'd0) begin
                  dnum_ff <= {sum_ff, 15'd0};
                  dden_ff <= {31'd0, count_ff};
                  drem_ff <= '0;
                  dq_ff <= '0;
                  cnt_ff <= 7'd1;
                  if (count_ff == '0) state_ff <= ST_OUT;
               end else begin
                  if (!dtrial[49]) begin
                     drem_ff <= dtrial[47:0];
                     dq_ff <= {dq_ff[62:0], 1'b1};
                  end else begin
                     drem_ff <= {drem_ff[46:0], dnum_ff[63]};
                     dq_ff <= {dq_ff[62:0], 1'b0};
                  end
                  dnum_ff <= dnum_ff << 1;
                  cnt_ff <= cnt_ff + 7'd1;
                  if (cnt_ff == 7'd49) state_ff <= ST_MEANEND;
               end
            end
            ST_MEANEND: begin
               mean_ff <= (dq_ff[63:32] != '0) ? '1 : dq_ff[31:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: if (!out_valid_ff || rsp_ready) begin
               out_valid_ff <= 1'b1;
               o_px_ff <= px_ff;
               o_py_ff <= py_ff;
               o_err_ff <= err_ff;
               o_mean_ff <= last_ff ? mean_ff : 32'd0;
               o_done_ff <= last_ff;
               o_status_ff <= wzero_ff ? STATUS_WZERO : (sat_ff ? STATUS_SAT : STATUS_OK);
               if (last_ff) begin
                  sum_ff <= '0;
                  count_ff <= '0;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_proj_x = o_px_ff;
   assign rsp_proj_y = o_py_ff;
   assign rsp_point_error = o_err_ff;
   assign rsp_mean_error = o_mean_ff;
   assign rsp_set_done = o_done_ff;
   assign rsp_status = o_status_ff;

   `REE_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_status != 2'd3, "bad status")
   `REE_ASSERT_IMP(a_wzero_err, clock, reset, rsp_valid && rsp_status == STATUS_WZERO, rsp_point_error == 32'hFFFF_FFFF, "w zero error")
   `REE_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// testbench for the reprojection error engine: directed table, then random camera phases
// depends on ree_pkg and reprojection_error_engine_unit
module tb;
   import ree_pkg::*;

   localparam int CAM_ZERO = 0;
   localparam int CAM_IDENT = 1;
   localparam int CAM_BIG = 2;
   localparam int CAM_LENS = 3;
   localparam int CAM_LENS_W0 = 4;
   localparam int CAM_MAXW = 5;
   localparam int CAM_MINW = 6;
   localparam int CAM_NOISE = 7;
   localparam int WatchdogLimit = 5000;
   localparam int SettleCycles = 700;
   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [49:0] SumMax = (50'd1 << 49) - 1;

   typedef struct packed {
      logic signed [31:0] proj_x;
      logic signed [31:0] proj_y;
      logic [31:0] point_error;
      logic [31:0] mean_error;
      logic set_done;
      logic [1:0] status;
   } pixel_result_type;

   typedef struct {
      int cam;
      logic signed [31:0] wx, wy, wz, ix, iy;
      logic last;
      bit typed;
      pixel_result_type res;
   } directed_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_world_x = 0, req_world_y = 0, req_world_z = 0;
   logic signed [31:0] req_image_x = 0, req_image_y = 0;
   logic req_last_point = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_proj_x, rsp_proj_y;
   logic [31:0] rsp_point_error, rsp_mean_error;
   logic rsp_set_done;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   csr_data_type csr_data = '0;

   reprojection_error_engine_unit dut (.*);

   always #6 clock = ~clock;

   // mirror of the camera and the set accumulator
   logic [63:0] cam_regs [0:5];
   logic [49:0] set_sum;
   logic [16:0] set_count;

   pixel_result_type pending_results [$];
   int mismatches = 0;
   int points_sent = 0, results_seen = 0, sets_closed = 0, wzero_seen = 0, sat_seen = 0;
   int idle_cycles = 0;
   bit quiet = 0;

   function automatic logic signed [63:0] cam_coef(int r, int c);
      logic [63:0] word;
      logic signed [31:0] half;
      word = cam_regs[2 * r + c / 2];
      half = c[0] ? word[63:32] : word[31:0];
      return half;
   endfunction

   function automatic logic signed [63:0] row_total(int r, logic signed [31:0] x,
                                                   logic signed [31:0] y, logic signed [31:0] z);
      logic signed [63:0] acc, a, b;
      acc = cam_coef(r, 3);
      for (int c = 0; c < 3; c++) begin
         a = cam_coef(r, c);
         b = (c == 0) ? x : (c == 1) ? y : z;
         acc = acc + ((a * b) >>> 16);
      end
      return acc;
   endfunction

   function automatic logic signed [63:0] divide_q16(logic signed [63:0] num,
                                                    logic signed [63:0] den, inout bit sat);
      bit neg;
      logic [63:0] un, ud, ip, rem, frac, mag, lim;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      ip = un / ud;
      rem = un % ud;
      frac = 0;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (ip > 64'd65536) begin
         sat = 1;
         return neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
      end
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         frac = frac << 1;
         if (rem >= ud) begin
            rem = rem - ud;
            frac[0] = 1'b1;
         end
      end
      mag = (ip << 16) | frac;
      if (mag > lim) begin
         sat = 1;
         mag = lim;
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic pixel_result_type project_point(logic signed [31:0] wx,
                                                      logic signed [31:0] wy,
                                                      logic signed [31:0] wz,
                                                      logic signed [31:0] ix,
                                                      logic signed [31:0] iy, logic last);
      pixel_result_type r;
      logic signed [63:0] u, v, w, px, py, dx, dy;
      logic [63:0] ax, ay, err, mean;
      logic [64:0] sq;
      bit sat;
      sat = 0;
      mean = 0;
      r.status = STATUS_OK;
      u = row_total(0, wx, wy, wz);
      v = row_total(1, wx, wy, wz);
      w = row_total(2, wx, wy, wz);
      if (w == 0) begin
         px = (u > 0) ? 64'sh7FFF_FFFF : (u < 0) ? -64'sh8000_0000 : 0;
         py = (v > 0) ? 64'sh7FFF_FFFF : (v < 0) ? -64'sh8000_0000 : 0;
         err = 64'hFFFF_FFFF;
         r.status = STATUS_WZERO;
      end else begin
         px = divide_q16(u, w, sat);
         py = divide_q16(v, w, sat);
         dx = px - ix;
         dy = py - iy;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         sq = {1'b0, ax * ax} + {1'b0, ay * ay};
         if (sq[64]) begin
            err = 64'hFFFF_FFFF;
            sat = 1;
         end else begin
            err = int_sqrt(sq[63:0]);
            if (err > 64'hFFFF_FFFF) begin
               err = 64'hFFFF_FFFF;
               sat = 1;
            end
         end
         if (sat) r.status = STATUS_SAT;
      end
      if (set_count < MaxPoints) begin
         set_sum = set_sum + err;
         if (set_sum > SumMax) set_sum = SumMax;
         set_count = set_count + 1;
      end
      if (last) begin
         if (set_count != 0) begin
            mean = set_sum / set_count;
            if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
         end
         set_sum = 0;
         set_count = 0;
      end
      r.proj_x = px[31:0];
      r.proj_y = py[31:0];
      r.point_error = err[31:0];
      r.mean_error = mean[31:0];
      r.set_done = last;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch on %s at result %0d: got %h, expected %h", what, results_seen, got, want);
   endtask

   // result side: random stalls, then a steady tail
   initial begin
      int k;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_ready <= 1;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            k = $urandom_range(1, 11);
            rsp_ready <= 0;
            repeat (k) @(negedge clock);
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_set_done) sets_closed++;
         if (rsp_status == STATUS_WZERO) wzero_seen++;
         if (rsp_status == STATUS_SAT) sat_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("unexpected result %0d with nothing outstanding", results_seen);
         end else begin
            want = pending_results.pop_front();
            if (rsp_proj_x !== want.proj_x) report_mismatch("proj_x", rsp_proj_x, want.proj_x);
            if (rsp_proj_y !== want.proj_y) report_mismatch("proj_y", rsp_proj_y, want.proj_y);
            if (rsp_point_error !== want.point_error)
               report_mismatch("point_error", rsp_point_error, want.point_error);
            if (rsp_mean_error !== want.mean_error)
               report_mismatch("mean_error", rsp_mean_error, want.mean_error);
            if (rsp_set_done !== want.set_done)
               report_mismatch("set_done", rsp_set_done, want.set_done);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // nothing moving for too long means the block is stuck
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("timeout: no handshake for %0d cycles", WatchdogLimit);
         $display("FAIL reprojection_error_engine_unit");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= CSR_R2R) cam_regs[idx] = value;
   endtask

   function automatic logic [63:0] pack_pair(logic [31:0] lo, logic [31:0] hi);
      return {hi, lo};
   endfunction

   task automatic load_camera(int kind);
      logic [63:0] regs [0:5];
      logic [31:0] f, cx, cy;
      f = $urandom_range(50, 2000) << 16;
      cx = $urandom_range(0, 1000) << 16;
      cy = $urandom_range(0, 1000) << 16;
      case (kind) inside
         CAM_IDENT: begin
            regs = '{pack_pair(ONE, 0), 0, pack_pair(0, ONE), 0, 0, pack_pair(0, ONE)};
         end
         CAM_BIG: begin
            regs = '{pack_pair(32'h7FFF_FFFF, 0), 0, pack_pair(0, 32'h8000_0000), 0,
                     0, pack_pair(ONE, 0)};
         end
         CAM_LENS, CAM_LENS_W0: begin
            regs[0] = pack_pair(f, $urandom_range(0, 'h3FFF));
            regs[1] = pack_pair(cx, $urandom_range(0, 20) << 16);
            regs[2] = pack_pair($urandom_range(0, 'h3FFF), f);
            regs[3] = pack_pair(cy, $urandom_range(0, 20) << 16);
            regs[4] = (kind == CAM_LENS_W0) ? 64'd0 :
                      pack_pair($urandom_range(0, 'hFFF), $urandom_range(0, 'hFFF));
            regs[5] = pack_pair(ONE, (kind == CAM_LENS_W0) ? 32'd0 : ONE);
         end
         CAM_MAXW: regs = '{default: {2{32'h7FFF_FFFF}}};
         CAM_MINW: regs = '{default: {2{32'h8000_0000}}};
         CAM_NOISE: begin
            foreach (regs[i]) regs[i] = {$urandom, $urandom};
         end
         default: regs = '{default: 64'd0};
      endcase
      for (int i = 0; i < 6; i++) csr_write(i[2:0], regs[i]);
      // indexes past the camera are ignored by the block
      if (kind == CAM_NOISE) begin
         csr_write(3'd6, {$urandom, $urandom});
         csr_write(3'd7, {$urandom, $urandom});
      end
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_point(logic signed [31:0] wx, logic signed [31:0] wy,
                             logic signed [31:0] wz, logic signed [31:0] ix,
                             logic signed [31:0] iy, logic last, bit typed,
                             pixel_result_type typed_res);
      int k;
      pixel_result_type r;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         k = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 0;
         repeat (k - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_world_x <= wx;
      req_world_y <= wy;
      req_world_z <= wz;
      req_image_x <= ix;
      req_image_y <= iy;
      req_last_point <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = project_point(wx, wy, wz, ix, iy, last);
      pending_results.insert(pending_results.size(), typed ? typed_res : r);
      points_sent++;
   endtask

   task automatic end_requests();
      @(negedge clock);
      req_valid <= 0;
   endtask

   directed_row_type directed [] = '{
      // zero camera after reset: w is zero everywhere
      '{CAM_ZERO, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1,
        '{0, 0, 32'hFFFF_FFFF, 0, 0, STATUS_WZERO}},
      '{CAM_ZERO, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1,
        '{0, 0, 32'hFFFF_FFFF, 0, 0, STATUS_WZERO}},
      '{CAM_ZERO, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1,
        '{0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_WZERO}},
      '{CAM_ZERO, 1, 1, 1, 1, 1, 1, 1,
        '{0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_WZERO}},
      // identity camera: pixel equals world x, y
      '{CAM_IDENT, 5 << 16, -(3 << 16), 7 << 16, 5 << 16, -(3 << 16), 0, 1,
        '{5 << 16, -(3 << 16), 0, 0, 0, STATUS_OK}},
      '{CAM_IDENT, 0, 0, 0, 3 << 16, 4 << 16, 1, 1,
        '{0, 0, 5 << 16, 32'h0002_8000, 1, STATUS_OK}},
      '{CAM_IDENT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, '0},
      '{CAM_IDENT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, '0},
      '{CAM_IDENT, 32'h0000_FFFF, 32'hFFFF_0001, 32'h5555_5555, 32'hAAAA_AAAA, 1, 1, 0, '0},
      // large gains: projection saturates, w of zero with signed rows, negative w
      '{CAM_BIG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE, 0, 0, 0, 0, '0},
      '{CAM_BIG, 32'h8000_0000, 32'h8000_0000, ONE, 0, 0, 0, 0, '0},
      '{CAM_BIG, 2 << 16, 3 << 16, 0, 0, 0, 0, 0, '0},
      '{CAM_BIG, -(2 << 16), -(3 << 16), 0, 0, 0, 0, 0, '0},
      '{CAM_BIG, 0, ONE, 0, 0, 0, 0, 0, '0},
      '{CAM_BIG, ONE, 32'h0000_0100, -ONE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, '0},
      '{CAM_BIG, 3, 5, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8765_4321, 1, 0, '0}
   };

   // one random point; well-formed points sit in front of the camera
   task automatic random_point(int kind, logic last);
      logic signed [31:0] wx, wy, wz, ix, iy;
      if (kind == CAM_LENS || kind == CAM_LENS_W0) begin
         if ($urandom_range(0, 9) == 0) begin
            wx = $urandom; wy = $urandom; wz = $urandom; ix = $urandom; iy = $urandom;
         end else begin
            wx = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            wy = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
            wz = (kind == CAM_LENS_W0 && $urandom_range(0, 9) == 0) ? 0 :
                 $urandom_range(ONE, 50 << 16);
            ix = $urandom_range(0, 2000 << 16);
            iy = $urandom_range(0, 2000 << 16);
         end
      end else begin
         wx = $urandom; wy = $urandom; wz = $urandom; ix = $urandom; iy = $urandom;
      end
      send_point(wx, wy, wz, ix, iy, last, 0, '0);
   endtask

   task automatic run_phase(int kind, int count, int tail_quiet);
      int left_in_set;
      wait_idle();
      load_camera(kind);
      left_in_set = $urandom_range(1, 20);
      for (int n = 0; n < count; n++) begin
         if (count - n <= tail_quiet) quiet = 1;
         left_in_set--;
         random_point(kind, left_in_set == 0 || n == count - 1);
         if (left_in_set == 0) left_in_set = $urandom_range(1, 20);
      end
      end_requests();
   endtask

   initial begin
      int cam_now;
      foreach (cam_regs[i]) cam_regs[i] = 0;
      set_sum = 0;
      set_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      cam_now = CAM_ZERO;
      foreach (directed[i]) begin
         if (directed[i].cam != cam_now) begin
            end_requests();
            wait_idle();
            load_camera(directed[i].cam);
            cam_now = directed[i].cam;
         end
         send_point(directed[i].wx, directed[i].wy, directed[i].wz, directed[i].ix,
                    directed[i].iy, directed[i].last, directed[i].typed, directed[i].res);
      end
      end_requests();

      run_phase(CAM_MAXW, 60, 0);
      run_phase(CAM_MINW, 60, 0);
      run_phase(CAM_NOISE, 410, 0);
      run_phase(CAM_LENS_W0, 600, 0);
      run_phase(CAM_LENS, 820, 200);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      $display("covered %0d points in %0d sets over eight camera settings", points_sent,
               sets_closed);
      $display("results: %0d checked, %0d with w zero, %0d saturated, %0d mismatches",
               results_seen, wzero_seen, sat_seen, mismatches);
      if (mismatches == 0)
         $display("PASS reprojection_error_engine_unit");
      else
         $display("FAIL reprojection_error_engine_unit");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ree_pkg.sv
rtl/reprojection_error_engine_unit.sv
test/tb.sv
